// File: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the DFS block. They expand to nothing
// when SYNTHESIS is defined. They expect signals named clk and rst_n in scope.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, expr, msg)
`endif

`endif

// File: src/dfs_pkg.sv
// ---------------------------------------------------------------------------
// dfs_pkg
// Shared constants, types and command codes for the DFS visit-order block.
// ---------------------------------------------------------------------------
package dfs_pkg;

    localparam int MAX_NODES        = 16;
    localparam int NODE_W           = 4;
    localparam int ROW_W            = 16;
    localparam int CNT_W            = 5;
    localparam int DEPTH_W          = $clog2(MAX_NODES + 1);
    localparam int NODE_COUNT_RESET = 16;

    // command queue between front and back
    localparam int CMD_DEPTH  = 4;
    localparam int CMD_PTR_W  = $clog2(CMD_DEPTH);
    localparam int CMD_FILL_W = $clog2(CMD_DEPTH + 1);

    // req_type encoding on the input channel
    localparam logic REQ_LOAD = 1'b0;

    typedef logic [NODE_W-1:0] node_t;
    typedef logic [ROW_W-1:0]  row_t;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_WALK,
        CMD_BAD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        node_t     row_index;
        row_t      row_bits;
        node_t     start_node;
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

endpackage

// File: src/dfs_in_if.sv
// ---------------------------------------------------------------------------
// dfs_in_if
// Request channel: load an adjacency row or start a walk.
// ---------------------------------------------------------------------------
interface dfs_in_if;
    import dfs_pkg::*;

    logic  valid;
    logic  ready;
    logic  req_type;
    node_t row_index;
    row_t  row_bits;
    node_t start_node;

    modport source (output valid, output req_type, output row_index, output row_bits,
                    output start_node, input ready);
    modport sink   (input valid, input req_type, input row_index, input row_bits,
                    input start_node, output ready);
endinterface

// File: src/dfs_out_if.sv
// ---------------------------------------------------------------------------
// dfs_out_if
// Result channel: nodes in depth-first preorder.
// ---------------------------------------------------------------------------
interface dfs_out_if;
    import dfs_pkg::*;

    logic  valid;
    logic  ready;
    node_t visited_node;
    logic  last;
    logic  bad_start;

    modport source (output valid, output visited_node, output last, output bad_start,
                    input ready);
    modport sink   (input valid, input visited_node, input last, input bad_start,
                    output ready);
endinterface

// File: src/dfs_front.sv
// ---------------------------------------------------------------------------
// dfs_front
// Accepts request items, classifies them and queues commands for the back end.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dfs_front (
    input  logic                        clk,
    input  logic                        rst_n,
    dfs_in_if.sink                      in_ch,
    input  logic [dfs_pkg::CNT_W-1:0]   node_count_used,
    output logic                        cmd_valid,
    output dfs_pkg::cmd_t               cmd,
    input  logic                        cmd_pop
);
    import dfs_pkg::*;

    cmd_t                  queue_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CMD_FILL_W-1:0] fill_reg, fill_next;
    logic                  push;
    cmd_t                  new_cmd;

    assign in_ch.ready = (fill_reg != CMD_FILL_W'(CMD_DEPTH));
    assign push        = in_ch.valid && in_ch.ready;
    assign cmd_valid   = (fill_reg != '0);
    assign cmd         = queue_mem[rd_ptr_reg];

    always_comb
    begin
        new_cmd.row_index  = in_ch.row_index;
        new_cmd.row_bits   = in_ch.row_bits;
        new_cmd.start_node = in_ch.start_node;
        if (in_ch.req_type == REQ_LOAD)
        begin
            new_cmd.kind = CMD_LOAD;
        end
        else if (CNT_W'(in_ch.start_node) >= node_count_used)
        begin
            new_cmd.kind = CMD_BAD;
        end
        else
        begin
            new_cmd.kind = CMD_WALK;
        end
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= new_cmd;
        end
    end

    `ASSERT_CLK(a_fill_bound, fill_reg <= CMD_FILL_W'(CMD_DEPTH), "command queue overfilled")
    `ASSERT_NEVER(a_pop_empty, cmd_pop && (fill_reg == '0), "pop from empty command queue")

endmodule

// File: src/dfs_back.sv
// ---------------------------------------------------------------------------
// dfs_back
// Executes queued commands: row writes, bad-start results and the
// depth-first walk with its path stack, visited mask and output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dfs_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  dfs_pkg::cmd_t               cmd,
    output logic                        cmd_pop,
    input  dfs_pkg::row_t               live_mask,
    dfs_out_if.source                   out_ch
);
    import dfs_pkg::*;

    state_t               state_reg, state_next;
    row_t                 adj_mem   [MAX_NODES];
    node_t                stack_mem [MAX_NODES];
    node_t                top_reg;
    node_t                pend_reg;
    logic [DEPTH_W-1:0]   depth_reg;
    row_t                 visited_reg;
    logic                 out_valid_reg;
    node_t                out_node_reg;
    logic                 out_last_reg;
    logic                 out_bad_reg;

    row_t                 edges;
    logic                 found;
    node_t                next_node;
    logic                 slot_free;
    logic                 depth_is_one;
    logic [DEPTH_W-1:0]   push_pos;
    logic [DEPTH_W-1:0]   below_pos;

    logic                 adj_we;
    logic                 do_init;
    logic                 do_clear;
    logic                 do_push;
    logic                 do_pop;
    logic                 do_done;
    logic                 emit;
    node_t                emit_node;
    logic                 emit_last;
    logic                 emit_bad;

    assign edges        = adj_mem[top_reg] & live_mask & ~visited_reg;
    assign found        = |edges;
    assign slot_free    = !out_valid_reg || out_ch.ready;
    assign depth_is_one = (depth_reg == DEPTH_W'(1));
    assign push_pos     = depth_reg - DEPTH_W'(1);
    assign below_pos    = depth_reg - DEPTH_W'(2);

    // lowest-index unvisited neighbor
    always_comb
    begin
        next_node = '0;
        for (int i = ROW_W - 1; i >= 0; i--)
        begin
            if (edges[i])
            begin
                next_node = NODE_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && (cmd.kind == CMD_WALK))
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!found && depth_is_one && slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd_pop   = 1'b0;
        adj_we    = 1'b0;
        do_init   = 1'b0;
        do_clear  = 1'b0;
        do_push   = 1'b0;
        do_pop    = 1'b0;
        do_done   = 1'b0;
        emit      = 1'b0;
        emit_node = pend_reg;
        emit_last = 1'b0;
        emit_bad  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_LOAD:
                        begin
                            cmd_pop = 1'b1;
                            adj_we  = 1'b1;
                        end
                        CMD_WALK:
                        begin
                            cmd_pop = 1'b1;
                            do_init = 1'b1;
                        end
                        CMD_BAD:
                        begin
                            if (slot_free)
                            begin
                                cmd_pop   = 1'b1;
                                do_clear  = 1'b1;
                                emit      = 1'b1;
                                emit_node = '0;
                                emit_last = 1'b1;
                                emit_bad  = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (found)
                begin
                    // previous node is known not to be last once a new one appears
                    if (slot_free)
                    begin
                        emit    = 1'b1;
                        do_push = 1'b1;
                    end
                end
                else if (depth_is_one)
                begin
                    if (slot_free)
                    begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                        do_done   = 1'b1;
                    end
                end
                else
                begin
                    do_pop = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            depth_reg     <= '0;
            visited_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_init)
            begin
                depth_reg   <= DEPTH_W'(1);
                visited_reg <= ROW_W'(1) << cmd.start_node;
            end
            else if (do_clear)
            begin
                visited_reg <= '0;
            end
            else if (do_push)
            begin
                depth_reg   <= depth_reg + DEPTH_W'(1);
                visited_reg <= visited_reg | (ROW_W'(1) << next_node);
            end
            else if (do_pop)
            begin
                depth_reg <= depth_reg - DEPTH_W'(1);
            end
            else if (do_done)
            begin
                depth_reg <= '0;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[cmd.row_index] <= cmd.row_bits;
        end
        if (do_init)
        begin
            top_reg  <= cmd.start_node;
            pend_reg <= cmd.start_node;
        end
        else if (do_push)
        begin
            stack_mem[push_pos[NODE_W-1:0]] <= top_reg;
            top_reg  <= next_node;
            pend_reg <= next_node;
        end
        else if (do_pop)
        begin
            top_reg <= stack_mem[below_pos[NODE_W-1:0]];
        end
        if (emit)
        begin
            out_node_reg <= emit_node;
            out_last_reg <= emit_last;
            out_bad_reg  <= emit_bad;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.visited_node = out_node_reg;
    assign out_ch.last         = out_last_reg;
    assign out_ch.bad_start    = out_bad_reg;

    `ASSERT_CLK(a_walk_depth, (state_reg == ST_WALK) |-> (depth_reg != '0), "walk with empty path")
    `ASSERT_CLK(a_top_visited, (state_reg == ST_WALK) |-> visited_reg[top_reg], "top not visited")
    `ASSERT_CLK(a_depth_bound, depth_reg <= DEPTH_W'(MAX_NODES), "path stack overflow")
    `ASSERT_CLK(a_last_idle, (emit && emit_last) |=> (state_reg == ST_IDLE), "last item but busy")

endmodule

// File: src/dfs_visit_order_unit.sv
// ---------------------------------------------------------------------------
// dfs_visit_order_unit
// Depth-first walk over a stored 16x16 adjacency matrix, preorder output.
// ---------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  in_ch     in    valid/ready    req_type, row_index, row_bits, start_node
//  out_ch    out   valid/ready    visited_node, last, bad_start
//  cfg       in    cfg_we         cfg_wdata = node_count
//
//  A load item is written to the matrix once it reaches the queue head and the
//  back end is idle. A walk sets up, then for each newly discovered node sends
//  the previous one and pushes the new one, or backtracks, and finally sends
//  the final node, each step set by the single adjacency-row read at the top
//  of the path stack. The front takes an item per cycle while its 4-entry
//  command queue has room; an out_ch stall holds the back end at its next
//  result, while backtracks still go on.
//  Reset: node_count = 16, queue empty, back end idle; matrix rows are
//  undefined until loaded.
// ---------------------------------------------------------------------------
module dfs_visit_order_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    dfs_in_if.sink                      in_ch,
    dfs_out_if.source                   out_ch,
    input  logic                        cfg_we,
    input  logic [dfs_pkg::CNT_W-1:0]   cfg_wdata
);
    import dfs_pkg::*;

    logic [CNT_W-1:0] node_count_reg;
    logic [CNT_W-1:0] count_used;
    row_t             live_mask;
    logic             cmd_valid;
    cmd_t             cmd;
    logic             cmd_pop;

    // node count register; the user must write it only while the block is idle (not enforced by the block)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= CNT_W'(NODE_COUNT_RESET);
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_wdata;
        end
    end

    // counts above the matrix size saturate
    assign count_used = (node_count_reg > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                              : node_count_reg;

    // edges to nodes at or above the count in use are masked off
    always_comb
    begin
        for (int i = 0; i < ROW_W; i++)
        begin
            live_mask[i] = (CNT_W'(i) < count_used);
        end
    end

    // front: accept, classify (load / walk / bad start), queue
    dfs_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_ch           (in_ch),
        .node_count_used (count_used),
        .cmd_valid       (cmd_valid),
        .cmd             (cmd),
        .cmd_pop         (cmd_pop)
    );

    // back: matrix storage, walk engine and output register
    dfs_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .live_mask (live_mask),
        .out_ch    (out_ch)
    );

endmodule

// File: test/tb_dfs_visit_order_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dfs_visit_order_unit
// Self-checking bench for the depth-first visit-order block. Items are
// queued by a stimulus process, pushed onto in_ch by a clocked driver and
// predicted as they are accepted. A clocked monitor pops the expected visits
// and checks every result on out_ch. node_count changes only while idle.
// ---------------------------------------------------------------------------
module tb_dfs_visit_order_unit;
    import dfs_pkg::*;

    localparam logic REQ_WALK = ~REQ_LOAD;

    // one item on the request channel
    typedef struct packed {
        logic  req_type;
        node_t row_index;
        row_t  row_bits;
        node_t start_node;
    } req_item_t;

    // one result on the visit channel
    typedef struct packed {
        node_t visited_node;
        logic  last;
        logic  bad_start;
    } visit_t;

    // -----------------------------------------------------------------------
    // Clock, reset and the signals the bench drives. Initializers give every
    // DUT input a known value from time zero.
    // -----------------------------------------------------------------------
    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             src_valid = 1'b0;
    req_item_t        src_item  = '0;
    logic             snk_ready = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;

    // idle odds in percent, per side
    int src_idle_pct = 0;
    int snk_idle_pct = 0;

    req_item_t pending_q[$];     // items waiting for the driver
    visit_t    visit_q[$];       // visits predicted but not yet seen
    row_t      adj_model [MAX_NODES];
    int        node_count_model = NODE_COUNT_RESET;
    int        error_count      = 0;

    dfs_in_if  in_ch();
    dfs_out_if out_ch();

    assign in_ch.valid      = src_valid;
    assign in_ch.req_type   = src_item.req_type;
    assign in_ch.row_index  = src_item.row_index;
    assign in_ch.row_bits   = src_item.row_bits;
    assign in_ch.start_node = src_item.start_node;
    assign out_ch.ready     = snk_ready;

    dfs_visit_order_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Walk predictor. Preorder DFS, lowest-index neighbor first, visited
    // neighbors skipped. Edges to nodes at or above the count are dropped.
    // A start at or beyond the count yields a single flagged result.
    // -----------------------------------------------------------------------
    function automatic void predict_walk(input node_t start);
        node_t  path [MAX_NODES];
        node_t  order [MAX_NODES];
        int     depth;
        int     emitted;
        int     nxt;
        row_t   seen;
        row_t   live;
        row_t   edges;
        visit_t v;
        begin
            if (int'(start) >= node_count_model)
            begin
                v.visited_node = '0;
                v.last         = 1'b1;
                v.bad_start    = 1'b1;
                visit_q = {visit_q, v};
                return;
            end
            live = (node_count_model >= ROW_W) ? '1 : row_t'((1 << node_count_model) - 1);
            seen = row_t'(1) << start;
            path[0]  = start;
            order[0] = start;
            depth    = 1;
            emitted  = 1;
            while (depth > 0)
            begin
                edges = adj_model[path[depth-1]] & live & ~seen;
                nxt   = -1;
                for (int j = 0; j < node_count_model; j++)
                begin
                    if (nxt < 0 && edges[j])
                        nxt = j;
                end
                if (nxt >= 0 && emitted < MAX_NODES && depth < MAX_NODES)
                begin
                    seen[nxt]      = 1'b1;
                    path[depth]    = node_t'(nxt);
                    order[emitted] = node_t'(nxt);
                    depth++;
                    emitted++;
                end
                else
                begin
                    depth--;    // backtrack
                end
            end
            for (int k = 0; k < emitted; k++)
            begin
                v.visited_node = order[k];
                v.last         = (k == emitted - 1);
                v.bad_start    = 1'b0;
                visit_q = {visit_q, v};
            end
        end
    endfunction

    // -----------------------------------------------------------------------
    // Driver: holds an item until accepted, then predicts it. A free slot
    // takes the next pending item unless the idle dice say otherwise.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
        end
        else
        begin
            if (src_valid && in_ch.ready)
            begin
                if (src_item.req_type == REQ_LOAD)
                    adj_model[src_item.row_index] = src_item.row_bits;
                else
                    predict_walk(src_item.start_node);
            end
            if (!src_valid || in_ch.ready)
            begin
                if (pending_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    src_item  <= pending_q.pop_front();
                    src_valid <= 1'b1;
                end
                else
                begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: every accepted visit must match the oldest prediction.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        visit_t want;
        if (!rst_n)
        begin
            snk_ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && snk_ready)
            begin
                if (visit_q.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected visit node %0d last %0b bad_start %0b",
                             $time, out_ch.visited_node, out_ch.last, out_ch.bad_start);
                end
                else
                begin
                    want = visit_q.pop_front();
                    if (out_ch.visited_node !== want.visited_node)
                    begin
                        error_count++;
                        $display("%0t: visited_node expected %0d actual %0d",
                                 $time, want.visited_node, out_ch.visited_node);
                    end
                    if (out_ch.last !== want.last)
                    begin
                        error_count++;
                        $display("%0t: last expected %0b actual %0b",
                                 $time, want.last, out_ch.last);
                    end
                    if (out_ch.bad_start !== want.bad_start)
                    begin
                        error_count++;
                        $display("%0t: bad_start expected %0b actual %0b",
                                 $time, want.bad_start, out_ch.bad_start);
                    end
                end
            end
            snk_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers. Fields a request does not use still get random bits.
    // -----------------------------------------------------------------------
    task automatic queue_load(input node_t row, input row_t bits);
        req_item_t it;
        begin
            it.req_type   = REQ_LOAD;
            it.row_index  = row;
            it.row_bits   = bits;
            it.start_node = node_t'($urandom);
            pending_q = {pending_q, it};
        end
    endtask

    task automatic queue_walk(input node_t start);
        req_item_t it;
        begin
            it.req_type   = REQ_WALK;
            it.row_index  = node_t'($urandom);
            it.row_bits   = row_t'($urandom);
            it.start_node = start;
            pending_q = {pending_q, it};
        end
    endtask

    // only called while the block is idle
    task automatic write_node_count(input int n);
        begin
            @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= CNT_W'(n);
            @(posedge clk);
            cfg_we    <= 1'b0;
            node_count_model = n;
        end
    endtask

    // Wait until every item went out and every visit came back, then let
    // queued loads (which produce nothing) settle in the back end.
    task automatic wait_drained();
        begin
            do
                @(negedge clk);
            while (pending_q.size() != 0 || src_valid || visit_q.size() != 0);
            repeat (80) @(posedge clk);
        end
    endtask

    // Short bursts: a few row loads then one or two walks. Now and then a
    // full reload as a forward chain with random back edges, which drives
    // the walk to full depth and makes it skip visited neighbors.
    task automatic queue_random_traffic(input int n_items);
        int   sent;
        int   n_loads;
        int   n_walks;
        row_t bits;
        begin
            sent = 0;
            while (sent < n_items)
            begin
                if ($urandom_range(9) == 0)
                begin
                    for (int i = 0; i < MAX_NODES; i++)
                    begin
                        if (i < MAX_NODES - 1)
                            bits = (row_t'(1) << (i + 1)) |
                                   (row_t'($urandom) & row_t'((1 << i) - 1));
                        else
                            bits = row_t'($urandom) & 16'h7fff;
                        queue_load(node_t'(i), bits);
                    end
                    sent += MAX_NODES;
                end
                else
                begin
                    n_loads = $urandom_range(3);
                    for (int i = 0; i < n_loads; i++)
                    begin
                        case ($urandom_range(5))
                            0:       bits = '0;
                            1:       bits = '1;
                            2:       bits = row_t'(1) << $urandom_range(15);
                            3:       bits = row_t'($urandom) & row_t'($urandom);
                            default: bits = row_t'($urandom);
                        endcase
                        queue_load(node_t'($urandom_range(15)), bits);
                    end
                    sent += n_loads;
                end
                n_walks = $urandom_range(1, 2);
                for (int i = 0; i < n_walks; i++)
                    queue_walk(node_t'($urandom_range(15)));
                sent += n_walks;
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        int count_plan [9];
        count_plan = '{16, 1, 0, 16, 2, 0, 1, 16, 0};   // 0 picks a random count

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct <= 38;
        snk_idle_pct <= 62;

        // Directed part. Every row is loaded before the first walk so no
        // walk ever reads an unwritten row.
        write_node_count(16);
        for (int i = 0; i < MAX_NODES; i++)
        begin
            if (i == 0)
                queue_load(node_t'(i), 16'h0002);
            else if (i == 1)
                queue_load(node_t'(i), 16'h8001);        // back edge to a visited node
            else if (i == 7)
                queue_load(node_t'(i), 16'h0000);        // dead end
            else if (i == MAX_NODES - 1)
                queue_load(node_t'(i), 16'hffff);        // edges everywhere, self too
            else
                queue_load(node_t'(i), row_t'(1) << (i + 1));
        end
        queue_walk(node_t'(0));     // reaches all sixteen nodes
        queue_walk(node_t'(7));     // single node, no edges
        queue_walk(node_t'(15));
        wait_drained();

        // one node in use: edges beyond the count are dropped
        write_node_count(1);
        queue_walk(node_t'(0));
        queue_walk(node_t'(15));    // bad start
        queue_walk(node_t'(1));     // bad start, just past the count
        wait_drained();

        write_node_count(5);
        queue_walk(node_t'(4));     // edge to node 5 is out of range
        queue_walk(node_t'(5));     // bad start at the boundary
        wait_drained();

        // Random part: three idle regimes, three counts in each
        for (int p = 0; p < 3; p++)
        begin
            if (p == 0)
            begin
                src_idle_pct <= 38;
                snk_idle_pct <= 62;
            end
            else if (p == 1)
            begin
                src_idle_pct <= 62;
                snk_idle_pct <= 38;
            end
            else
            begin
                src_idle_pct <= 0;
                snk_idle_pct <= 0;
            end
            for (int s = 0; s < 3; s++)
            begin
                if (count_plan[p*3 + s] == 0)
                    write_node_count($urandom_range(1, 16));
                else
                    write_node_count(count_plan[p*3 + s]);
                queue_random_traffic(18);
                wait_drained();
            end
        end

        if (error_count == 0)
            $display("tb_dfs_visit_order_unit OK");
        else
            $display("tb_dfs_visit_order_unit NOT OK");
        $finish;
    end

    // hang guard, far above the slowest legal run
    initial
    begin
        #5_000_000;
        $display("tb_dfs_visit_order_unit NOT OK");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/dfs_pkg.sv
src/dfs_in_if.sv
src/dfs_out_if.sv
src/dfs_front.sv
src/dfs_back.sv
src/dfs_visit_order_unit.sv
test/tb_dfs_visit_order_unit.sv
